FILE: hdl/gkg_pkg.sv
// Shared constants, types and helpers for the Gaussian kernel generator.
package gkg_pkg;

	localparam int MAX_SIZE_DEF = 64;

	// 2*ln(10) in Q16
	localparam logic [31:0] LN10X2_Q16 = 32'd301804;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	// exponent limit 24.0 in Q16
	localparam logic [20:0] EXP_CAP_Q16 = 21'd1572864;

	localparam int DIVD_W = 64;
	localparam int DIVS_W = 32;
	localparam int NB_W = 5;

	// quotient bit counts for the two divisions
	localparam logic [NB_W-1:0] A16_BITS = 5'd21;
	localparam logic [NB_W-1:0] COEF_BITS = 5'd17;

	localparam logic [2:0] TAY_TERMS = 3'd5;
	localparam logic [2:0] SQ_LAST = 3'd7;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// floor(2^32 / j) for the Taylor term divisors
	function automatic logic [31:0] recip(input logic [2:0] j);
		logic [31:0] r;
		case (j)
			3'd2: r = 32'd2147483648;
			3'd3: r = 32'd1431655765;
			3'd4: r = 32'd1073741824;
			3'd5: r = 32'd858993459;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/gkg_div.sv
// Restoring divider, one quotient bit per cycle.
module gkg_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [gkg_pkg::DIVD_W-1:0]      dividend,
	input  logic [gkg_pkg::DIVS_W-1:0]      divisor,
	input  logic [gkg_pkg::NB_W-1:0]        nbits,
	output gkg_pkg::div_stat_t              stat,
	output logic [gkg_pkg::DIVS_W-1:0]      quotient
);

	logic [gkg_pkg::DIVS_W-1:0] rem_q;
	logic [gkg_pkg::DIVS_W-1:0] dvs_q;
	logic [gkg_pkg::DIVD_W-1:0] lo_q;
	logic [gkg_pkg::DIVS_W-1:0] quo_q;
	logic [gkg_pkg::NB_W-1:0]   cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [gkg_pkg::DIVS_W:0]   trial;
	logic                       ge;

	assign trial = {rem_q, lo_q[gkg_pkg::DIVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};

	// caller guarantees dividend >> nbits is below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= gkg_pkg::DIVS_W'(dividend >> nbits);
			lo_q <= dividend << (gkg_pkg::DIVD_W - int'(nbits));
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? gkg_pkg::DIVS_W'(trial - {1'b0, dvs_q}) : trial[gkg_pkg::DIVS_W-1:0];
			lo_q <= lo_q << 1;
			quo_q <= {quo_q[gkg_pkg::DIVS_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gkg_pkg::NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/gaussian_kernel_generator_core.sv
// Setup takes the length from kernel_length when use_length is set, else searches for it from precision.
// Each sample then runs on one multiplier and one divider: the 21-bit division, five Taylor terms
// and eight squarings; past the exponent cap the sample is written as zero without the series.
// Each coefficient needs a 17-bit division (none when the mass is empty) and then waits out any coef_stall.
// One request at a time: req_stall is high from acceptance until the last coefficient is taken.
// Reset (arst_n low) returns the sequencer to idle; the sample memory is not cleared.
module gaussian_kernel_generator_core #(
	parameter int MAX_SIZE = gkg_pkg::MAX_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [15:0]       std_dev,
	input  logic              use_length,
	input  logic [6:0]        kernel_length,
	input  logic [11:0]       precision,
	output logic              coef_valid,
	input  logic              coef_stall,
	output logic [16:0]       coefficient,
	output logic signed [6:0] position,
	output logic              last
);

	localparam int N_W = $clog2(MAX_SIZE + 1);
	localparam int I_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int K_W = N_W + 2;
	localparam int KSQ_W = 2 * (K_W - 1);
	localparam int HMAX = (MAX_SIZE - 1) / 2;
	localparam int H_W = $clog2(HMAX + 2);
	localparam int SUM_W = 18 + $clog2(MAX_SIZE);

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_LEN_S2   = 5'd1;
	localparam logic [4:0] ST_LEN_PL   = 5'd2;
	localparam logic [4:0] ST_LEN_PROD = 5'd3;
	localparam logic [4:0] ST_LEN_CEIL = 5'd4;
	localparam logic [4:0] ST_LEN_SRCH = 5'd5;
	localparam logic [4:0] ST_SMP_K    = 5'd6;
	localparam logic [4:0] ST_SMP_CHK  = 5'd7;
	localparam logic [4:0] ST_SMP_DIV  = 5'd8;
	localparam logic [4:0] ST_TAY_MUL  = 5'd9;
	localparam logic [4:0] ST_TAY_REC  = 5'd10;
	localparam logic [4:0] ST_TAY_FIX  = 5'd11;
	localparam logic [4:0] ST_SQ_MUL   = 5'd12;
	localparam logic [4:0] ST_SQ_ACC   = 5'd13;
	localparam logic [4:0] ST_SMP_WR   = 5'd14;
	localparam logic [4:0] ST_OUT_RD   = 5'd15;
	localparam logic [4:0] ST_OUT_DIV  = 5'd16;
	localparam logic [4:0] ST_OUT_WAIT = 5'd17;
	localparam logic [4:0] ST_OUT_HOLD = 5'd18;

	logic [4:0]       state_q;
	logic [15:0]      s_q;
	logic [11:0]      p_q;
	logic             uselen_q;
	logic [31:0]      s2_q;
	logic [23:0]      prodc_q;
	logic [H_W-1:0]   h_q;
	logic [23:0]      hsq_q;
	logic [N_W-1:0]   n_q;
	logic [I_W-1:0]   i_q;
	logic [SUM_W-1:0] sum_q;
	logic             zero_q;
	logic [26:0]      t_q;
	logic [30:0]      pe_q;
	logic [27:0]      x_q;
	logic [2:0]       j_q;
	logic [2:0]       sq_cnt_q;
	logic [17:0]      rd_q;
	logic [63:0]      mul_q;
	logic [17:0]      store_q [MAX_SIZE];

	logic             coef_valid_q;
	logic [16:0]      coef_q;
	logic [6:0]       pos_q;
	logic             last_q;

	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          prod_c;
	logic signed [K_W-1:0] k;
	logic [K_W-2:0]       abs_k;
	logic [KSQ_W-1:0]     ksq;
	logic [63:0]          a_dividend;
	logic                 a_big;
	logic [20:0]          a16;
	logic [27:0]          q_est;
	logic [27:0]          r_est;
	logic [27:0]          q_fix;
	logic [17:0]          wval;
	logic [N_W-1:0]       n_len;
	logic                 is_last;

	logic                 div_start;
	logic [63:0]          div_dividend;
	logic [31:0]          div_divisor;
	logic [4:0]           div_nbits;
	gkg_pkg::div_stat_t   div_stat;
	logic [31:0]          div_quo;

	gkg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// centered offset in half samples: 2i - (n-1)
	assign k = K_W'($signed({1'b0, i_q, 1'b0})) - K_W'($signed({1'b0, n_q})) + K_W'(1);
	assign abs_k = k[K_W-1] ? (K_W-1)'(-k) : (K_W-1)'(k);
	assign ksq = mul_q[KSQ_W-1:0];
	assign a_dividend = (64'(ksq) << 29) + 64'(s2_q >> 1);
	assign a_big = a_dividend >= (64'(s2_q) << 21);
	assign a16 = div_quo[20:0];
	assign is_last = N_W'(i_q) == n_q - N_W'(1);

	assign q_est = (j_q == 3'd1) ? x_q : 28'(mul_q[63:32]);
	assign r_est = x_q - 28'(q_est * j_q);
	assign q_fix = q_est + 28'(r_est >= 28'(j_q));

	assign wval = zero_q ? 18'd0 : 18'((32'(pe_q) + 32'd4096) >> 13);

	always_comb begin
		if (kernel_length == 7'd0)
			n_len = N_W'(1);
		else if (int'(kernel_length) > MAX_SIZE)
			n_len = N_W'(MAX_SIZE);
		else
			n_len = N_W'(kernel_length);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LEN_S2: begin
				mul_a = 32'(s_q);
				mul_b = 32'(s_q);
			end
			ST_LEN_PL: begin
				mul_a = 32'(p_q);
				mul_b = gkg_pkg::LN10X2_Q16;
			end
			ST_LEN_PROD: begin
				mul_a = s2_q;
				mul_b = 32'(mul_q[30:0]);
			end
			ST_SMP_K: begin
				mul_a = 32'(abs_k);
				mul_b = 32'(abs_k);
			end
			ST_TAY_MUL: begin
				mul_a = 32'(t_q);
				mul_b = 32'(pe_q);
			end
			ST_TAY_REC: begin
				mul_a = 32'(mul_q[57:30]);
				mul_b = gkg_pkg::recip(j_q);
			end
			ST_SQ_MUL: begin
				mul_a = 32'(pe_q);
				mul_b = 32'(pe_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	always_comb begin
		div_start = 1'b0;
		div_dividend = a_dividend;
		div_divisor = s2_q;
		div_nbits = gkg_pkg::A16_BITS;
		if (state_q == ST_SMP_CHK) begin
			div_start = !a_big;
		end else if (state_q == ST_OUT_DIV) begin
			div_start = sum_q != '0;
			div_dividend = (64'(rd_q) << 16) + 64'(sum_q >> 1);
			div_divisor = 32'(sum_q);
			div_nbits = gkg_pkg::COEF_BITS;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= prod_c;
		if (state_q == ST_SMP_WR)
			store_q[i_q] <= wval;
		rd_q <= store_q[i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coef_valid_q <= 1'b0;
			uselen_q <= 1'b0;
			n_q <= '0;
			i_q <= '0;
			sum_q <= '0;
			h_q <= '0;
			hsq_q <= '0;
			j_q <= '0;
			sq_cnt_q <= '0;
			zero_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						s_q <= (std_dev == 16'd0) ? 16'd1 : std_dev;
						p_q <= precision;
						uselen_q <= use_length;
						n_q <= n_len;
						state_q <= ST_LEN_S2;
					end
				end
				ST_LEN_S2: state_q <= ST_LEN_PL;
				ST_LEN_PL: begin
					s2_q <= mul_q[31:0];
					i_q <= '0;
					sum_q <= '0;
					state_q <= uselen_q ? ST_SMP_K : ST_LEN_PROD;
				end
				ST_LEN_PROD: state_q <= ST_LEN_CEIL;
				ST_LEN_CEIL: begin
					prodc_q <= 24'(mul_q[63:40]) + 24'(mul_q[39:0] != '0);
					h_q <= '0;
					hsq_q <= '0;
					state_q <= ST_LEN_SRCH;
				end
				ST_LEN_SRCH: begin
					// smallest h (at most HMAX) with h^2 at or above the scaled target
					if (int'(h_q) < HMAX && hsq_q < prodc_q) begin
						h_q <= h_q + 1'b1;
						hsq_q <= hsq_q + 24'({h_q, 1'b1});
					end else begin
						n_q <= N_W'({h_q, 1'b1});
						state_q <= ST_SMP_K;
					end
				end
				ST_SMP_K: state_q <= ST_SMP_CHK;
				ST_SMP_CHK: begin
					if (a_big) begin
						zero_q <= 1'b1;
						state_q <= ST_SMP_WR;
					end else begin
						state_q <= ST_SMP_DIV;
					end
				end
				ST_SMP_DIV: begin
					if (div_stat.done) begin
						if (a16 > gkg_pkg::EXP_CAP_Q16) begin
							zero_q <= 1'b1;
							state_q <= ST_SMP_WR;
						end else begin
							zero_q <= 1'b0;
							t_q <= {a16, 6'd0};
							pe_q <= gkg_pkg::Q30_ONE;
							j_q <= gkg_pkg::TAY_TERMS;
							state_q <= ST_TAY_MUL;
						end
					end
				end
				ST_TAY_MUL: state_q <= ST_TAY_REC;
				ST_TAY_REC: begin
					x_q <= mul_q[57:30];
					state_q <= ST_TAY_FIX;
				end
				ST_TAY_FIX: begin
					pe_q <= gkg_pkg::Q30_ONE - 31'(q_fix);
					if (j_q == 3'd1) begin
						sq_cnt_q <= '0;
						state_q <= ST_SQ_MUL;
					end else begin
						j_q <= j_q - 3'd1;
						state_q <= ST_TAY_MUL;
					end
				end
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					pe_q <= 31'((mul_q + 64'h2000_0000) >> 30);
					if (sq_cnt_q == gkg_pkg::SQ_LAST) begin
						state_q <= ST_SMP_WR;
					end else begin
						sq_cnt_q <= sq_cnt_q + 3'd1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SMP_WR: begin
					sum_q <= sum_q + SUM_W'(wval);
					if (is_last) begin
						i_q <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_SMP_K;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_DIV;
				ST_OUT_DIV: begin
					pos_q <= 7'(k);
					last_q <= is_last;
					if (sum_q == '0) begin
						// no mass: split evenly between the two central taps
						coef_q <= (abs_k == (K_W-1)'(1)) ? 17'd32768 : 17'd0;
						coef_valid_q <= 1'b1;
						state_q <= ST_OUT_HOLD;
					end else begin
						state_q <= ST_OUT_WAIT;
					end
				end
				ST_OUT_WAIT: begin
					if (div_stat.done) begin
						coef_q <= div_quo[16:0];
						coef_valid_q <= 1'b1;
						state_q <= ST_OUT_HOLD;
					end
				end
				ST_OUT_HOLD: begin
					if (!coef_stall) begin
						coef_valid_q <= 1'b0;
						if (last_q) begin
							i_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign coef_valid = coef_valid_q;
	assign coefficient = coef_q;
	assign position = pos_q;
	assign last = last_q;

endmodule
